### sv/acfd_pkg.sv
package acfd_pkg;

   localparam int unsigned MAX_DATA_BYTES = 8;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned ID_W = 16;
   localparam int unsigned LEN_W = 4;
   localparam int unsigned COUNT_W = 5;

   localparam int unsigned RSP_ID_LSB = 0;
   localparam int unsigned RSP_LEN_LSB = RSP_ID_LSB + ID_W;
   localparam int unsigned RSP_BYTE_LSB = RSP_LEN_LSB + LEN_W;
   localparam int unsigned RSP_USED_W = RSP_BYTE_LSB + 8 * MAX_DATA_BYTES;
   localparam int unsigned RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic [CHAR_W-1:0] START_CHAR = 8'h4D;
   localparam logic [3:0] HEADER_LEN = 4'd11;
   localparam logic [3:0] LEN_POS = 4'd4;
   localparam logic [3:0] ID_FIRST = 4'd6;
   localparam logic [3:0] ID_LAST = 4'd9;

   localparam logic [1:0] SUB_HIGH = 2'd0;
   localparam logic [1:0] SUB_LOW = 2'd1;
   localparam logic [1:0] SUB_SEP = 2'd2;

   typedef logic [7:0] byte_type;

   function automatic logic [3:0] dec_digit(input logic [CHAR_W-1:0] c);
      logic [3:0] value;
      value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         value = c[3:0];
      end
      return value;
   endfunction

   function automatic logic [3:0] hex_digit(input logic [CHAR_W-1:0] c);
      logic [3:0] value;
      value = dec_digit(c);
      if (c inside {[8'h41:8'h46]}) begin
         value = 4'(c[3:0] + 4'd9);
      end
      return value;
   endfunction

endpackage

### sv/ascii_can_frame_decoder.sv
// A character transfer on req is registered and decoded in the next cycle; a frame that
// completes on it is written to the result register, once free, and raises rsp_tvalid.
// Throughput: one character per cycle; req_tready drops only while a finished frame waits
// in the result register and the next registered character would complete another.
// Reset clears the parse phase, the header counter and both valid flags; the data bytes
// are cleared each time a header completes.
module ascii_can_frame_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [acfd_pkg::CHAR_W-1:0]     req_tdata,  // rx_char
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // frame_id, frame_length, byte0 .. byte7, zero padding
   output logic [acfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser   // length_error
);
   import acfd_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HEADER = 2'd1,
      PH_DATA   = 2'd2
   } phase_type;

   logic                  in_valid_ff;
   logic [CHAR_W-1:0]     in_char_ff;

   phase_type             phase_ff, phase_in;
   logic [3:0]            header_count_ff, header_count_in;
   logic [LEN_W-1:0]      length_ff, length_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [COUNT_W-1:0]    char_count_ff, char_count_in;
   logic [1:0]            sub_ff, sub_in;
   logic [2:0]            byte_idx_ff, byte_idx_in;
   byte_type              data_ff [MAX_DATA_BYTES];
   byte_type              data_in [MAX_DATA_BYTES];

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff;

   logic                  emit_c;
   logic                  error_c;
   logic                  advance_c;
   logic                  in_header_c;
   logic [3:0]            pos_c;
   logic [LEN_W-1:0]      length_base_c;
   logic [ID_W-1:0]       id_base_c;
   logic [COUNT_W:0]      total_c;

   always_comb begin
      phase_in = phase_ff;
      header_count_in = header_count_ff;
      length_in = length_ff;
      id_in = id_ff;
      char_count_in = char_count_ff;
      sub_in = sub_ff;
      byte_idx_in = byte_idx_ff;
      data_in = data_ff;
      emit_c = 1'b0;
      error_c = 1'b0;
      total_c = 6'({length_ff, 1'b0}) + 6'(length_ff) - 6'd1;

      in_header_c = (phase_ff == PH_HEADER) ||
                    ((phase_ff != PH_DATA) && (in_char_ff == START_CHAR));
      pos_c = (phase_ff == PH_HEADER) ? header_count_ff : 4'd0;
      length_base_c = (phase_ff == PH_HEADER) ? length_ff : '0;
      id_base_c = (phase_ff == PH_HEADER) ? id_ff : '0;

      if (in_header_c) begin
         length_in = length_base_c;
         id_in = id_base_c;
         if (pos_c == LEN_POS) begin
            length_in = dec_digit(in_char_ff);
         end else if ((pos_c >= ID_FIRST) && (pos_c <= ID_LAST)) begin
            id_in = {id_base_c[ID_W-5:0], hex_digit(in_char_ff)};
         end
         header_count_in = 4'(pos_c + 4'd1);
         phase_in = PH_HEADER;
         if (header_count_in == HEADER_LEN) begin
            for (int j = 0; j < MAX_DATA_BYTES; j++) begin
               data_in[j] = '0;
            end
            char_count_in = '0;
            sub_in = SUB_HIGH;
            byte_idx_in = '0;
            if (length_in > LEN_W'(MAX_DATA_BYTES)) begin
               phase_in = PH_IDLE;
               emit_c = 1'b1;
               error_c = 1'b1;
            end else if (length_in == '0) begin
               phase_in = PH_IDLE;
               emit_c = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
      end else if (phase_ff == PH_DATA) begin
         case (sub_ff)
            SUB_HIGH: begin
               data_in[byte_idx_ff] = {hex_digit(in_char_ff), 4'd0};
               sub_in = SUB_LOW;
            end
            SUB_LOW: begin
               data_in[byte_idx_ff] = 8'(data_ff[byte_idx_ff] + 8'(hex_digit(in_char_ff)));
               sub_in = SUB_SEP;
            end
            default: begin
               sub_in = SUB_HIGH;
               byte_idx_in = 3'(byte_idx_ff + 3'd1);
            end
         endcase
         char_count_in = COUNT_W'(char_count_ff + 5'd1);
         if ({1'b0, char_count_in} >= total_c) begin
            phase_in = PH_IDLE;
            emit_c = 1'b1;
         end
      end

      rsp_data_in = '0;
      rsp_data_in[RSP_ID_LSB +: ID_W] = id_in;
      rsp_data_in[RSP_LEN_LSB +: LEN_W] = length_in;
      for (int j = 0; j < MAX_DATA_BYTES; j++) begin
         rsp_data_in[RSP_BYTE_LSB + 8 * j +: 8] = data_in[j];
      end
   end

   assign advance_c = in_valid_ff && (!emit_c || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff <= PH_IDLE;
         header_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance_c) begin
            phase_ff <= phase_in;
            header_count_ff <= header_count_in;
         end
         if (advance_c && emit_c) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
      end
      if (advance_c) begin
         length_ff <= length_in;
         id_ff <= id_in;
         char_count_ff <= char_count_in;
         sub_ff <= sub_in;
         byte_idx_ff <= byte_idx_in;
         data_ff <= data_in;
      end
      if (advance_c && emit_c) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= error_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

### sv/acfd_checker.sv
module acfd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [acfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);
   import acfd_pkg::*;

   logic [LEN_W-1:0] length_c;

   assign length_c = rsp_tdata[RSP_LEN_LSB +: LEN_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Result changed while stalled.");

   a_error_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         length_c > LEN_W'(MAX_DATA_BYTES) &&
         rsp_tdata[RSP_BYTE_LSB +: 8 * MAX_DATA_BYTES] == '0)
      else $error("Dropped frame carries a valid length or data bytes.");

   a_good_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> length_c <= LEN_W'(MAX_DATA_BYTES))
      else $error("Accepted frame has a length above the limit.");

   a_padding: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RSP_USED_W] == '0)
      else $error("Padding bits of the result are not zero.");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("Result offered or input not ready right after reset.");

endmodule

bind ascii_can_frame_decoder acfd_checker u_acfd_checker (.*);

### test/can_frame_checker.sv
module can_frame_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [acfd_pkg::CHAR_W-1:0]      req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [acfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tuser,
   output int                               fail_count,
   output int                               pending,
   output int                               frames_checked,
   output int                               errors_checked
);
   import acfd_pkg::*;

   typedef enum logic [1:0] {PARSE_IDLE, PARSE_HEADER, PARSE_DATA} parse_state_type;

   typedef struct packed {
      logic [ID_W-1:0]                id;
      logic [LEN_W-1:0]               len;
      logic                           err;
      logic [MAX_DATA_BYTES-1:0][7:0] data;
   } can_frame_type;

   parse_state_type                state;
   logic [3:0]                     hdr_pos;
   logic [LEN_W-1:0]               len_digit;
   logic [ID_W-1:0]                id_acc;
   logic [COUNT_W-1:0]             data_pos;
   logic [MAX_DATA_BYTES-1:0][7:0] data_acc;
   can_frame_type                  awaited_frames[$];

   function automatic logic [3:0] decimal_value(input logic [CHAR_W-1:0] ch);
      if (ch >= 8'h30 && ch <= 8'h39) begin
         return 4'(ch - 8'h30);
      end
      return 4'd0;
   endfunction

   function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] ch);
      if (ch >= 8'h41 && ch <= 8'h46) begin
         return 4'(ch - 8'h37);
      end
      return decimal_value(ch);
   endfunction

   task automatic log_frame(input logic err);
      can_frame_type f;
      f.id = id_acc;
      f.len = len_digit;
      f.err = err;
      f.data = data_acc;
      awaited_frames = {awaited_frames, f};
   endtask

   task automatic decode_char(input logic [CHAR_W-1:0] ch);
      int slot;
      int sub;
      if (state != PARSE_HEADER && state != PARSE_DATA) begin
         if (ch != START_CHAR) begin
            return;
         end
         state = PARSE_HEADER;
         hdr_pos = 4'd0;
         id_acc = '0;
         len_digit = '0;
      end
      if (state == PARSE_HEADER) begin
         if (hdr_pos == LEN_POS) begin
            len_digit = decimal_value(ch);
         end else if (hdr_pos >= ID_FIRST && hdr_pos <= ID_LAST) begin
            id_acc = {id_acc[ID_W-5:0], hex_value(ch)};
         end
         hdr_pos = hdr_pos + 4'd1;
         if (hdr_pos == HEADER_LEN) begin
            data_acc = '0;
            data_pos = '0;
            if (len_digit > MAX_DATA_BYTES) begin
               state = PARSE_IDLE;
               log_frame(1'b1);
            end else if (len_digit == 0) begin
               state = PARSE_IDLE;
               log_frame(1'b0);
            end else begin
               state = PARSE_DATA;
            end
         end
      end else begin
         slot = int'(data_pos) / 3;
         sub = int'(data_pos) % 3;
         if (slot < MAX_DATA_BYTES) begin
            if (sub == int'(SUB_HIGH)) begin
               data_acc[slot] = {hex_value(ch), 4'h0};
            end else if (sub == int'(SUB_LOW)) begin
               data_acc[slot] = data_acc[slot] + 8'(hex_value(ch));
            end
         end
         data_pos = data_pos + 5'd1;
         if (int'(data_pos) >= int'(len_digit) * 3 - 1) begin
            state = PARSE_IDLE;
            log_frame(1'b0);
         end
      end
   endtask

   task automatic compare_frame();
      can_frame_type want;
      logic [7:0] got_byte;
      int errs;
      errs = 0;
      if (awaited_frames.size() == 0) begin
         $error("frame transfer with no frame awaited: data %h, length_error %b",
                rsp_tdata, rsp_tuser);
         fail_count <= fail_count + 1;
         return;
      end
      want = awaited_frames.pop_front();
      if (rsp_tdata[RSP_ID_LSB +: ID_W] != want.id) begin
         $error("frame_id expected %h, got %h", want.id, rsp_tdata[RSP_ID_LSB +: ID_W]);
         errs++;
      end
      if (rsp_tdata[RSP_LEN_LSB +: LEN_W] != want.len) begin
         $error("frame_length expected %0d, got %0d", want.len,
                rsp_tdata[RSP_LEN_LSB +: LEN_W]);
         errs++;
      end
      if (rsp_tuser != want.err) begin
         $error("length_error expected %b, got %b", want.err, rsp_tuser);
         errs++;
      end
      for (int k = 0; k < MAX_DATA_BYTES; k++) begin
         got_byte = rsp_tdata[RSP_BYTE_LSB + 8 * k +: 8];
         if (got_byte != want.data[k]) begin
            $error("byte%0d expected %h, got %h", k, want.data[k], got_byte);
            errs++;
         end
      end
      fail_count <= fail_count + errs;
      frames_checked <= frames_checked + 1;
      if (want.err) begin
         errors_checked <= errors_checked + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         state = PARSE_IDLE;
         hdr_pos = 4'd0;
         len_digit = '0;
         id_acc = '0;
         data_pos = '0;
         data_acc = '0;
         awaited_frames.delete();
         fail_count <= 0;
         frames_checked <= 0;
         errors_checked <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_char(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            compare_frame();
         end
      end
      pending <= awaited_frames.size();
   end

endmodule

### test/tb_top.sv
module tb_top;
   import acfd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CHAR_W-1:0]     req_tdata = '0;     // rx_char
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // frame_id, frame_length, byte0 .. byte7, padding
   logic                  rsp_tuser;          // length_error

   int fail_count;
   int pending;
   int frames_checked;
   int errors_checked;
   int cycle_count = 0;
   int send_idle_pct = 23;
   int recv_stall_pct = 71;
   int chars_sent = 0;
   int frame_chars = 0;

   logic [CHAR_W-1:0] text_q[$];
   string hex_chars = "0123456789ABCDEF";

   ascii_can_frame_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   can_frame_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .fail_count     (fail_count),
      .pending        (pending),
      .frames_checked (frames_checked),
      .errors_checked (errors_checked)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic add_char(input logic [CHAR_W-1:0] ch);
      text_q = {text_q, ch};
   endtask

   task automatic send_char(input logic [CHAR_W-1:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      chars_sent++;
   endtask

   task automatic flush_text(input bit counted);
      foreach (text_q[i]) begin
         send_char(text_q[i]);
      end
      if (counted) begin
         frame_chars += text_q.size();
      end
      text_q.delete();
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i]);
      end
   endtask

   function automatic logic [CHAR_W-1:0] any_hex();
      int r;
      r = $urandom_range(99);
      if (r < 85) begin
         return hex_chars[$urandom_range(15)];
      end else if (r < 92) begin
         return 8'h61 + 8'($urandom_range(5));
      end
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [CHAR_W-1:0] filler();
      if ($urandom_range(99) < 70) begin
         return 8'($urandom_range(126, 32));
      end
      return 8'($urandom_range(255));
   endfunction

   task automatic queue_frame(input bit cut);
      logic [CHAR_W-1:0] len_char;
      int r;
      int n;
      r = $urandom_range(99);
      if (r < 70) begin
         len_char = 8'h31 + 8'($urandom_range(7));
      end else if (r < 78) begin
         len_char = 8'h30;
      end else if (r < 86) begin
         len_char = 8'h39;
      end else begin
         len_char = 8'($urandom_range(255));
      end
      add_char(START_CHAR);
      for (int k = 1; k < int'(HEADER_LEN); k++) begin
         if (k == int'(LEN_POS)) begin
            add_char(len_char);
         end else if (k >= int'(ID_FIRST) && k <= int'(ID_LAST)) begin
            add_char(any_hex());
         end else begin
            add_char(filler());
         end
      end
      n = (len_char >= 8'h31 && len_char <= 8'h38) ? int'(len_char - 8'h30) * 3 - 1 : 0;
      for (int k = 0; k < n; k++) begin
         add_char((k % 3 == 2) ? filler() : any_hex());
      end
      if (cut) begin
         repeat ($urandom_range(text_q.size() - 1, 1)) begin
            void'(text_q.pop_back());
         end
      end
   endtask

   task automatic random_traffic(input int char_budget);
      int first;
      int r;
      first = frame_chars;
      while (frame_chars - first < char_budget) begin
         r = $urandom_range(99);
         if (r < 80) begin
            queue_frame(1'b0);
            flush_text(1'b1);
         end else if (r < 90) begin
            queue_frame(1'b1);
            flush_text(1'b1);
         end else begin
            repeat ($urandom_range(6, 1)) begin
               add_char(8'($urandom_range(255)));
            end
            flush_text(1'b0);
         end
      end
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Idle noise, then zero length, oversized length and a letter as length digit.
      add_char(8'h00);
      add_char(8'hFF);
      push_text("m");
      push_text("Mxyz0-FFFF-");
      push_text("Mxyz9-1a2G-12 34");
      push_text("MxyzA-0000-");
      // Full eight-byte frame with digit boundaries and a start character among the data.
      push_text("M0008-0000-FF 00 A5 5A 0F F0 @G M7");
      push_text("Mzzz1-@G:/-F9");
      flush_text(1'b1);

      random_traffic(400);
      hold_until_drained();
      send_idle_pct = 71;
      recv_stall_pct = 23;
      random_traffic(400);
      hold_until_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_traffic(400);

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d characters (%0d inside frames) under three pacing settings.",
               chars_sent, frame_chars);
      $display("Checked %0d decoded frames, %0d of them flagged with a length error.",
               frames_checked, errors_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
